// ===== rtl/core/f2i_pkg.sv =====
// ----------------------------------------------------------------------------
// f2i_pkg
// shared types and constants for the float32 to integer type converter
// ----------------------------------------------------------------------------
package f2i_pkg;

    localparam int unsigned EXACT_LIMIT_DEF = 16777216;

    typedef enum logic [3:0] {
        OP_BOOL  = 4'd0,
        OP_BYTE  = 4'd1,
        OP_DINT  = 4'd2,
        OP_DWORD = 4'd3,
        OP_INT   = 4'd4,
        OP_LINT  = 4'd5,
        OP_LREAL = 4'd6,
        OP_SINT  = 4'd7,
        OP_UDINT = 4'd8,
        OP_UINT  = 4'd9,
        OP_USINT = 4'd10,
        OP_WORD  = 4'd11
    } t_op;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] value_bits;
    } t_in;

    typedef struct packed {
        logic [63:0] result;
        logic        eno;
        logic        input_invalid;
    } t_out;

endpackage

// ===== rtl/core/float32_to_integer_types_convert.sv =====
// ----------------------------------------------------------------------------
// float32_to_integer_types_convert
// single-precision value to IEC integer types, round half away from zero
// ----------------------------------------------------------------------------
// One word is taken per cycle while busy is low (busy is always low). The
// word is registered in r_in, converted by one pass of shift/compare/increment
// logic and its result is registered in r_out and shown with o_valid high for
// one cycle. Throughput is one word per clock; the receiver cannot stall, so
// every result must be taken when presented.
module float32_to_integer_types_convert
    import f2i_pkg::*;
#(
    parameter int unsigned EXACT_LIMIT = EXACT_LIMIT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_data,
    output logic o_valid,
    output t_out o_data
);

    localparam logic [40:0] LIM = 41'(EXACT_LIMIT);

    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;
    t_out n_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start;
            r_out_vld <= r_in_vld;
        end
        if (start) begin
            r_in <= i_data;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // decode and round
    logic [7:0]  e_raw;
    logic [8:0]  e;
    logic [22:0] m;
    logic [23:0] sig;
    logic        bad;
    logic        sgn;
    logic [40:0] t;
    logic [40:0] r;
    logic        half;
    logic        fz;
    logic        neg;
    logic        rneg;
    logic [4:0]  sh;
    logic [40:0] shl;
    logic [23:0] rmask;
    logic [23:0] rem;
    logic [31:0] w32;
    logic [63:0] wide;
    logic [4:0]  lz;
    logic [22:0] mn;
    logic        nb128;
    logic        nb32k;

    always_comb begin
        e_raw = r_in.value_bits[30:23];
        m     = r_in.value_bits[22:0];
        sgn   = r_in.value_bits[31];
        bad   = (e_raw == 8'hFF);
        sig   = {(e_raw != 8'd0), m};
        e     = (e_raw == 8'd0) ? 9'd1 : {1'b0, e_raw};
        half  = 1'b0;
        fz    = 1'b0;
        sh    = '0;
        rmask = '0;
        rem   = '0;
        shl   = '0;
        if (e >= 9'd150) begin
            // anything past 41 bits saturates every check, cap at 2^40
            if ((e - 9'd150) > 9'd17) begin
                t = 41'h100_0000_0000;
            end else begin
                shl = {17'd0, sig} << (e - 9'd150);
                t   = shl;
            end
        end else if ((9'd150 - e) >= 9'd25) begin
            t  = '0;
            fz = (sig != 24'd0);
        end else begin
            sh    = 5'(9'd150 - e);
            rmask = ~(24'hFF_FFFF << sh);
            rem   = sig & rmask;
            t     = 41'(sig >> sh);
            half  = rem[sh - 5'd1];
            fz    = (rem != 24'd0);
        end
        r    = t + 41'(half);
        neg  = sgn && ((t != 41'd0) || fz);
        rneg = neg && (r != 41'd0);

        if (r >= 41'h8000_0000) begin
            w32 = 32'h8000_0000;
        end else begin
            w32 = neg ? (32'd0 - r[31:0]) : r[31:0];
        end

        nb128 = (r > 41'd128) || ((r == 41'd128) && fz);
        nb32k = (r > 41'd32768) || ((r == 41'd32768) && fz);

        // widen to double
        lz = '0;
        for (int i = 22; i >= 0; i--) begin
            if (m[i] && lz == 5'd0 && (m >> (i + 1)) == 23'd0) begin
                lz = 5'(22 - i);
            end
        end
        mn = 23'(m << (lz + 5'd1));
        if (bad) begin
            wide = {sgn, 11'h7FF, (m != 23'd0), m[21:0], 29'd0};
        end else if (e_raw == 8'd0) begin
            if (m == 23'd0) begin
                wide = {sgn, 63'd0};
            end else begin
                wide = {sgn, 11'(11'd896 - 11'(lz)), mn, 29'd0};
            end
        end else begin
            wide = {sgn, 11'(e_raw) + 11'd896, m, 29'd0};
        end

        n_out.input_invalid = bad;
        n_out.eno           = 1'b1;
        n_out.result        = '0;
        if (r_in.op == OP_LREAL) begin
            n_out.result = wide;
            n_out.eno    = !bad;
        end else if (r_in.op > OP_WORD) begin
            n_out.eno = 1'b0;
        end else if (bad) begin
            n_out.eno = 1'b0;
            if (r_in.op == OP_BOOL) begin
                n_out.result = 64'd1;
            end else if (r_in.op == OP_DINT) begin
                n_out.result = 64'h8000_0000;
            end else if (r_in.op == OP_LINT) begin
                n_out.result = 64'h8000_0000_0000_0000;
            end
        end else begin
            unique case (r_in.op)
                OP_BOOL: begin
                    n_out.result = 64'((t != 41'd0) || fz);
                end
                OP_BYTE, OP_USINT: begin
                    n_out.eno    = !((r > 41'd255) || rneg);
                    n_out.result = {56'd0, w32[7:0]};
                end
                OP_UINT, OP_WORD: begin
                    n_out.eno    = !((r > 41'd65535) || rneg);
                    n_out.result = {48'd0, w32[15:0]};
                end
                OP_SINT: begin
                    n_out.eno    = neg ? !nb128 : !(r > 41'd127);
                    n_out.result = {56'd0, w32[7:0]};
                end
                OP_INT: begin
                    n_out.eno    = neg ? !nb32k : !(r > 41'd32767);
                    n_out.result = {48'd0, w32[15:0]};
                end
                OP_DINT: begin
                    n_out.eno    = !(r >= LIM);
                    n_out.result = {32'd0, w32};
                end
                OP_LINT: begin
                    if ((neg && r >= LIM) || (!neg && t >= LIM)) begin
                        n_out.eno    = 1'b0;
                        n_out.result = 64'h8000_0000_0000_0000;
                    end else begin
                        n_out.result = neg ? (64'd0 - 64'(r)) : 64'(r);
                    end
                end
                OP_DWORD, OP_UDINT: begin
                    if ((!neg && r >= LIM) || rneg) begin
                        n_out.eno    = 1'b0;
                        n_out.result = (r_in.op == OP_DWORD) ? 64'hFFFF_FFFF
                                                             : 64'h8000_0000;
                    end else begin
                        n_out.result = {32'd0, r[31:0]};
                    end
                end
                default: begin
                    n_out.eno = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/float32_to_integer_types_convert_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float32_to_integer_types_convert_tb
// checks the float32 to integer type converter against a built-in predictor:
// directed corner words, then random words biased toward the rounding and
// range boundaries, with random gaps on the sending side
// ----------------------------------------------------------------------------
module float32_to_integer_types_convert_tb;
    import f2i_pkg::*;

    localparam int unsigned LIMIT = 16777216;
    localparam int WATCHDOG_CYCLES = 2000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_data;
    logic o_valid;
    t_out o_data;

    int mismatches;
    int words_sent;
    int words_checked;
    int idle_cycles;

    float32_to_integer_types_convert u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // predicted conversion of one word
    function automatic t_out convert_word(input t_in w);
        t_out   o;
        logic [7:0]  e;
        logic [63:0] sig, t, r, rem, res, wr, mm;
        logic        half, fz, neg, rneg, bad, eno;
        int unsigned sh, ex, k;
        e   = w.value_bits[30:23];
        sig = {41'd0, w.value_bits[22:0]};
        half = 1'b0;
        fz   = 1'b0;
        ex  = e;
        if (e != 0) sig[23] = 1'b1;
        else ex = 1;
        if (ex >= 150) begin
            sh = ex - 150;
            t  = (sh > 39) ? (64'd1 << 40) : (sig << sh);
        end else begin
            sh = 150 - ex;
            if (sh >= 25) begin
                t  = 0;
                fz = (sig != 0);
            end else begin
                rem  = sig & ((64'd1 << sh) - 1);
                t    = sig >> sh;
                half = rem >= (64'd1 << (sh - 1));
                fz   = (rem != 0);
            end
        end
        r    = t + half;
        neg  = w.value_bits[31] && (t != 0 || fz);
        rneg = neg && r != 0;
        bad  = (e == 8'hFF);
        // 32-bit wrap, pinned at the most negative value from 2^31 up
        if (r >= 64'h8000_0000) wr = 64'h8000_0000;
        else wr = (neg ? (64'd0 - r) : r) & 64'hFFFF_FFFF;
        res = 0;
        eno = 1'b1;
        if (w.op == OP_LREAL) begin
            eno = !bad;
            mm  = {41'd0, w.value_bits[22:0]};
            if (bad) begin
                res = {w.value_bits[31], 11'h7FF, 52'd0} | (mm << 29);
                if (mm != 0) res[51] = 1'b1;
            end else if (e == 0) begin
                if (mm == 0) res = {w.value_bits[31], 63'd0};
                else begin
                    k = 0;
                    while (mm[23] == 1'b0) begin
                        mm = mm << 1;
                        k++;
                    end
                    res = {w.value_bits[31], 63'd0} | (64'(897 - k) << 52)
                        | ((mm & 64'h7F_FFFF) << 29);
                end
            end else begin
                res = {w.value_bits[31], 63'd0} | (64'(ex + 896) << 52) | (mm << 29);
            end
        end else if (w.op > OP_WORD) begin
            eno = 1'b0;
        end else if (bad) begin
            eno = 1'b0;
            case (w.op)
                OP_BOOL: res = 1;
                OP_DINT: res = 64'h8000_0000;
                OP_LINT: res = 64'h8000_0000_0000_0000;
                default: res = 0;
            endcase
        end else begin
            case (w.op)
                OP_BOOL: res = (t != 0 || fz);
                OP_BYTE, OP_USINT: begin
                    eno = !(r > 255 || rneg);
                    res = wr & 64'hFF;
                end
                OP_UINT, OP_WORD: begin
                    eno = !(r > 65535 || rneg);
                    res = wr & 64'hFFFF;
                end
                OP_SINT: begin
                    eno = neg ? !(r > 128 || (r == 128 && fz)) : !(r > 127);
                    res = wr & 64'hFF;
                end
                OP_INT: begin
                    eno = neg ? !(r > 32768 || (r == 32768 && fz)) : !(r > 32767);
                    res = wr & 64'hFFFF;
                end
                OP_DINT: begin
                    eno = !(r >= LIMIT);
                    res = wr;
                end
                OP_LINT: begin
                    if ((neg && r >= LIMIT) || (!neg && t >= LIMIT)) begin
                        eno = 1'b0;
                        res = 64'h8000_0000_0000_0000;
                    end else res = neg ? (64'd0 - r) : r;
                end
                OP_DWORD, OP_UDINT: begin
                    if ((!neg && r >= LIMIT) || rneg) begin
                        eno = 1'b0;
                        res = (w.op == OP_DWORD) ? 64'hFFFF_FFFF : 64'h8000_0000;
                    end else res = r & 64'hFFFF_FFFF;
                end
                default: begin
                    eno = 1'b0;
                    res = 0;
                end
            endcase
        end
        o.result        = res;
        o.eno           = eno;
        o.input_invalid = bad;
        return o;
    endfunction

    class conversion_scoreboard;
        t_out pending[$];
        t_in  sources[$];

        function void note_word(t_in w);
            pending.push_back(convert_word(w));
            sources.push_back(w);
        endfunction

        task check_word(t_out got);
            t_out exp_o;
            t_in  src;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            exp_o = pending.pop_front();
            src   = sources.pop_front();
            if (got.result !== exp_o.result)
                report_mismatch($sformatf("op %0d x %h result %h want %h",
                    src.op, src.value_bits, got.result, exp_o.result));
            if (got.eno !== exp_o.eno)
                report_mismatch($sformatf("op %0d x %h eno %b want %b",
                    src.op, src.value_bits, got.eno, exp_o.eno));
            if (got.input_invalid !== exp_o.input_invalid)
                report_mismatch($sformatf("op %0d x %h invalid %b want %b",
                    src.op, src.value_bits, got.input_invalid, exp_o.input_invalid));
            words_checked++;
        endtask
    endclass

    conversion_scoreboard sb = new();

    // results sampled at the edge that ends their cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_word(o_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog expired");
            $display("float32_to_integer_types_convert test failed");
            $finish;
        end
    end

    // start stays high after the accept edge; the next call or the caller drops it
    task automatic send_word(input logic [3:0] op, input logic [31:0] x, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= '{op: op, value_bits: x};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_word('{op: op, value_bits: x});
        words_sent++;
    endtask

    // random float near an integer boundary of interest, often on a .5
    function automatic logic [31:0] near_value(input int unsigned mag);
        shortreal f;
        int d;
        d = $urandom_range(0, 4);
        f = shortreal'(mag) + ((d == 0) ? 0.5 : (d == 1) ? -0.5 :
            (d == 2) ? 0.0 : (d == 3) ? 0.4999 : 1.0);
        if ($urandom_range(0, 1)) f = -f;
        return $shortrealtobits(f);
    endfunction

    function automatic logic [31:0] random_value();
        int unsigned sel;
        int unsigned mags[12] = '{0, 1, 127, 128, 255, 256, 32767, 32768,
                                  65535, 65536, 16777215, 16777216};
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1:    return $urandom();
            2:       return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom())};
            3:       return {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 2)),
                             23'($urandom())};
            4:       return {$urandom_range(0, 1) == 1, 8'($urandom_range(150, 190)),
                             23'($urandom())};
            default: return near_value(mags[$urandom_range(0, 11)]);
        endcase
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    endfunction

    initial begin
        logic [31:0] corners[16] = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000,
            32'hBF00_0000, 32'h3FC0_0000, 32'hBFC0_0000, 32'h7F80_0000,
            32'hFF80_0000, 32'h7FC0_0001, 32'hFF80_0001, 32'h0000_0001,
            32'h4B80_0000, 32'hCB80_0000, 32'h4F00_0000, 32'h7F7F_FFFF,
            32'hC300_8000};
        int n;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        start   <= 1'b0;
        i_data  <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every selector once, then corner values on rotating selectors
        for (int op = 0; op < 16; op++) send_word(4'(op), 32'hC2FF_0000, 0);
        for (int i = 0; i < 16; i++) send_word(4'(i * 5), corners[i], 0);

        // hold off until the pipeline drains
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);

        for (n = 0; n < 1150; n++) begin
            if (n % 200 < 40) send_word(4'($urandom_range(0, 15)), random_value(), 0);
            else send_word(4'($urandom_range(0, 15)), random_value(), draw_gap());
            if (n == 600) begin
                start <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        $display("sent %0d words over all 16 selectors, checked %0d results", words_sent,
                 words_checked);
        $display("covered NaN, infinity, subnormal, half-way and range-limit values");
        if (mismatches == 0) begin
            $display("float32_to_integer_types_convert test passed");
        end else begin
            $display("float32_to_integer_types_convert test failed");
        end
        $finish;
    end

endmodule
